[sv/btr_pkg.sv]
// ============================================================================
// btr_pkg - shared types and constants of the bitmap text rasterizer
// Holds the sequencer states, the configuration register indexes, the
// control group of the dot output and the 5x7 font table.
// ============================================================================
package btr_pkg;

    // one glyph is 7 rows of 5 dots, top row in the upper bits, bit 4 leftmost
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_GLYPH_SCALE = 3'd2,
        CFG_TEXT_COLOR  = 3'd3,
        CFG_USE_CAMERA  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_ADV_4,
        ST_ADV_2
    } t_state;

    // control group of the dot output register
    typedef struct packed {
        logic valid;
        logic last;
    } t_dot_ctrl;

    // 5x7 font; the code is already folded to upper case
    function automatic logic [GLYPH_BITS-1:0] font_lookup(input logic [7:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
            8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
            8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
            8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
            8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F}; // G
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
            8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
            8'h4A: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E}; // J
            8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
            8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
            8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04}; // V
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}; // W
            8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}; // X
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
            8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
            8'h33: g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E}; // 3
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
            8'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E}; // 5
            8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}; // 9
            8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
            8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06}; // period
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // dash
            8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}; // slash
            8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // bang
            8'h20: g = '0;                                                 // space
            default: g = {5'h1F, 5'h11, 5'h05, 5'h0A, 5'h04, 5'h00, 5'h04}; // fallback
        endcase
        return g;
    endfunction

endpackage

[sv/btr_char_if.sv]
// ============================================================================
// btr_char_if - character input channel
// Valid/ready channel that carries one character code per transaction.
// ============================================================================
interface btr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_text;

    modport source (output valid, output char_code, output start_of_text, input ready);
    modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

[sv/btr_rect_if.sv]
// ============================================================================
// btr_rect_if - square output channel
// Valid/ready channel that carries one lit square per transaction.
// ============================================================================
interface btr_rect_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic        [4:0]  rect_size;
    logic        [31:0] rect_color;
    logic               camera_space;
    logic               last_of_char;

    modport source (output valid, output rect_x, output rect_y, output rect_size,
                    output rect_color, output camera_space, output last_of_char,
                    input ready);
    modport sink   (input valid, input rect_x, input rect_y, input rect_size,
                    input rect_color, input camera_space, input last_of_char,
                    output ready);
endinterface

[sv/bitmap_text_rasterizer.sv]
// ============================================================================
// bitmap_text_rasterizer - 5x7 font character generator
// Turns a stream of character codes into lit squares at a text cursor.
// ============================================================================
// Usage:
//   i_char carries one character per transaction; start_of_text reloads the
//   cursor from the origin registers first. o_rect carries one square per lit
//   font dot, top row first and left to right, last_of_char on the final one.
//   A newline returns the cursor to the origin column, moves it down by eight
//   dots and sends nothing.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// Timing:
//   A character is taken in the idle state, looked up in the next, then the
//   sequencer walks the glyph one dot per cycle through the shared coordinate
//   adder while the output register is free, sees that no lit dot is left and
//   moves the cursor in ADV_4 and then ADV_2. A newline goes back to idle from
//   the lookup. i_char.ready is high only between characters, so no character
//   is taken while one is still walked. The first square is offered from the
//   output register once the walk reaches the first lit dot.
// Reset and stalls:
//   Reset sets the configuration registers to defaults, the cursor to (0, 0).
//   A stalled receiver holds the output register and freezes the dot walk;
//   a character can be taken while the last square still waits.
// ============================================================================
module bitmap_text_rasterizer #(
    parameter int COORD_BITS = 16,
    parameter int MAX_SCALE  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [btr_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [btr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    btr_char_if.sink                            i_char,
    btr_rect_if.source                          o_rect
);
    import btr_pkg::*;

    localparam int         SCALE_CAP  = (MAX_SCALE > 31) ? 31 : MAX_SCALE;
    localparam logic [4:0] SCALE_MAX5 = 5'(SCALE_CAP);

    logic [15:0]             r_origin_x;
    logic [15:0]             r_origin_y;
    logic [4:0]              r_glyph_scale;
    logic [31:0]             r_text_color;
    logic                    r_use_camera;

    logic [4:0]              w_scale;
    logic [COORD_BITS-1:0]   w_origin_x;
    logic [COORD_BITS-1:0]   w_origin_y;
    logic [7:0]              w_rom_code;
    logic [GLYPH_BITS-1:0]   w_rom_glyph;
    t_dot_ctrl               w_dot_ctrl;
    logic [COORD_BITS-1:0]   w_dot_x;
    logic [COORD_BITS-1:0]   w_dot_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_glyph_scale <= 5'd1;
            r_text_color  <= '1;
            r_use_camera  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data[15:0];
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[15:0];
                CFG_GLYPH_SCALE: r_glyph_scale <= i_cfg_data[4:0];
                CFG_TEXT_COLOR:  r_text_color  <= i_cfg_data[31:0];
                CFG_USE_CAMERA:  r_use_camera  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the dot size into 1..MAX_SCALE, with MAX_SCALE capped at 31
    always_comb begin
        if (r_glyph_scale == 5'd0) begin
            w_scale = 5'd1;
        end else if (r_glyph_scale > SCALE_MAX5) begin
            w_scale = SCALE_MAX5;
        end else begin
            w_scale = r_glyph_scale;
        end
    end

    // sign-extend or cut the origin to the coordinate width
    assign w_origin_x = COORD_BITS'($signed(r_origin_x));
    assign w_origin_y = COORD_BITS'($signed(r_origin_y));

    btr_glyph_rom u_glyph_rom (
        .i_code  (w_rom_code),
        .o_glyph (w_rom_glyph)
    );

    btr_dot_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_dot_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_valid    (i_char.valid),
        .i_char_code     (i_char.char_code),
        .i_start_of_text (i_char.start_of_text),
        .o_char_ready    (i_char.ready),
        .i_origin_x      (w_origin_x),
        .i_origin_y      (w_origin_y),
        .i_scale         (w_scale),
        .o_rom_code      (w_rom_code),
        .i_rom_glyph     (w_rom_glyph),
        .i_dot_ready     (o_rect.ready),
        .o_dot_ctrl      (w_dot_ctrl),
        .o_dot_x         (w_dot_x),
        .o_dot_y         (w_dot_y)
    );

    // size, color, camera flag must change only between texts; not enforced
    assign o_rect.valid        = w_dot_ctrl.valid;
    assign o_rect.last_of_char = w_dot_ctrl.last;
    assign o_rect.rect_x       = 16'($signed(w_dot_x));
    assign o_rect.rect_y       = 16'($signed(w_dot_y));
    assign o_rect.rect_size    = w_scale;
    assign o_rect.rect_color   = r_text_color;
    assign o_rect.camera_space = r_use_camera;

`ifndef SYNTHESIS
    // the sequencer is busy in the lookup state that follows a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_char.valid && i_char.ready) |=> !i_char.ready)
        else $error("character taken in back-to-back cycles");

    // squares always carry a clamped, nonzero size
    a_size_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rect.valid |-> (o_rect.rect_size != 5'd0 && o_rect.rect_size <= SCALE_MAX5))
        else $error("square size outside the clamped range");

    // a new square only appears while a glyph is being walked
    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rect.valid) |-> !i_char.ready)
        else $error("square emitted while the sequencer is idle");
`endif

endmodule

[sv/btr_glyph_rom.sv]
// ============================================================================
// btr_glyph_rom - case folding and font lookup
// Folds lower-case letters to upper case and returns the 35-dot bitmap.
// ============================================================================
module btr_glyph_rom (
    input  logic [7:0]                  i_code,
    output logic [btr_pkg::GLYPH_BITS-1:0] o_glyph
);
    import btr_pkg::*;

    logic [7:0] w_folded;

    // fold a..z onto A..Z
    always_comb begin
        if (i_code >= CHAR_LOWER_A && i_code <= CHAR_LOWER_Z) begin
            w_folded = i_code - CASE_OFFSET;
        end else begin
            w_folded = i_code;
        end
    end

    assign o_glyph = font_lookup(w_folded);

endmodule

[sv/btr_dot_seq.sv]
// ============================================================================
// btr_dot_seq - dot scan sequencer
// Walks a glyph to its last lit dot, one per cycle unless the output stalls,
// keeps the cursor, drives the dot output. One shared adder does every step.
// ============================================================================
module btr_dot_seq #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_char_valid,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_start_of_text,
    output logic                           o_char_ready,
    input  logic [COORD_BITS-1:0]          i_origin_x,
    input  logic [COORD_BITS-1:0]          i_origin_y,
    input  logic [4:0]                     i_scale,
    output logic [7:0]                     o_rom_code,
    input  logic [btr_pkg::GLYPH_BITS-1:0] i_rom_glyph,
    input  logic                           i_dot_ready,
    output btr_pkg::t_dot_ctrl             o_dot_ctrl,
    output logic [COORD_BITS-1:0]          o_dot_x,
    output logic [COORD_BITS-1:0]          o_dot_y
);
    import btr_pkg::*;

    localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);

    t_state                  r_state, n_state;
    logic [7:0]              r_code, n_code;
    logic [COORD_BITS-1:0]   r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0]   r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0]   r_dot_x, n_dot_x;
    logic [COORD_BITS-1:0]   r_dot_y, n_dot_y;
    logic [GLYPH_BITS-1:0]   r_glyph, n_glyph;
    logic [2:0]              r_col, n_col;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_last, n_out_last;
    logic [COORD_BITS-1:0]   r_out_x, n_out_x;
    logic [COORD_BITS-1:0]   r_out_y, n_out_y;

    logic [COORD_BITS-1:0]   w_add_a;
    logic [COORD_BITS-1:0]   w_add_b;
    logic [COORD_BITS-1:0]   w_add_sum;
    logic                    w_out_free;

    // shared adder: pick operands by sequencer step, scale multiples are shifts
    always_comb begin
        w_add_a = r_dot_x;
        w_add_b = COORD_BITS'(i_scale);
        unique case (r_state)
            ST_LOOKUP: begin
                w_add_a = r_cur_y;
                w_add_b = COORD_BITS'({i_scale, 3'b000});
            end
            ST_SCAN: begin
                w_add_a = (r_col == COL_LAST) ? r_dot_y : r_dot_x;
                w_add_b = COORD_BITS'(i_scale);
            end
            ST_ADV_4: begin
                w_add_a = r_cur_x;
                w_add_b = COORD_BITS'({i_scale, 2'b00});
            end
            ST_ADV_2: begin
                w_add_a = r_cur_x;
                w_add_b = COORD_BITS'({i_scale, 1'b0});
            end
            default: begin
                w_add_a = r_dot_x;
                w_add_b = COORD_BITS'(i_scale);
            end
        endcase
    end

    assign w_add_sum  = w_add_a + w_add_b;
    assign w_out_free = !r_out_valid || i_dot_ready;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_dot_x     = r_dot_x;
        n_dot_y     = r_dot_y;
        n_glyph     = r_glyph;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;

        // drop the held dot once the receiver takes it
        if (r_out_valid && i_dot_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_char_valid) begin
                    n_code = i_char_code;
                    if (i_start_of_text) begin
                        n_cur_x = i_origin_x;
                        n_cur_y = i_origin_y;
                    end
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (r_code == CHAR_NEWLINE) begin
                    n_cur_x = i_origin_x;
                    n_cur_y = w_add_sum;
                    n_state = ST_IDLE;
                end else begin
                    n_glyph = i_rom_glyph;
                    n_dot_x = r_cur_x;
                    n_dot_y = r_cur_y;
                    n_col   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_glyph == '0) begin
                    // no lit dot left: go advance the cursor
                    n_state = ST_ADV_4;
                end else if (w_out_free) begin
                    if (r_glyph[GLYPH_BITS-1]) begin
                        n_out_valid = 1'b1;
                        n_out_x     = r_dot_x;
                        n_out_y     = r_dot_y;
                        n_out_last  = (r_glyph[GLYPH_BITS-2:0] == '0);
                    end
                    n_glyph = {r_glyph[GLYPH_BITS-2:0], 1'b0};
                    if (r_col == COL_LAST) begin
                        n_col   = '0;
                        n_dot_x = r_cur_x;
                        n_dot_y = w_add_sum;
                    end else begin
                        n_col   = r_col + 3'd1;
                        n_dot_x = w_add_sum;
                    end
                end
            end
            ST_ADV_4: begin
                n_cur_x = w_add_sum;
                n_state = ST_ADV_2;
            end
            ST_ADV_2: begin
                n_cur_x = w_add_sum;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_dot_x    <= n_dot_x;
        r_dot_y    <= n_dot_y;
        r_glyph    <= n_glyph;
        r_col      <= n_col;
        r_out_last <= n_out_last;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
    end

    assign o_char_ready     = (r_state == ST_IDLE);
    assign o_rom_code       = r_code;
    assign o_dot_ctrl.valid = r_out_valid;
    assign o_dot_ctrl.last  = r_out_last;
    assign o_dot_x          = r_out_x;
    assign o_dot_y          = r_out_y;

endmodule
